@@ hw/rtl/mab_pkg.sv @@
package mab_pkg;

  localparam int unsigned MaxPixels = 65536;
  localparam int unsigned AddrW     = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
  localparam int unsigned CntW      = $clog2(MaxPixels + 1);
  localparam int unsigned PixelW    = 32;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    SET_ORIG = 2'd0,
    SET_POS  = 2'd1,
    SET_NEG  = 2'd2
  } set_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  function automatic logic [7:0] med3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] m2;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m2 = (hi < c) ? hi : c;
    return (lo > m2) ? lo : m2;
  endfunction

  function automatic logic [7:0] cov_pos(logic [7:0] m);
    logic [10:0] v;
    v = {m, 3'b000} - 11'd892;
    if (m <= 8'd111) return 8'd0;
    else if (m >= 8'd144) return 8'd255;
    else return v[7:0];
  endfunction

  function automatic logic [7:0] cov_neg(logic [7:0] m);
    logic [10:0] v;
    v = 11'd1148 - {m, 3'b000};
    if (m <= 8'd111) return 8'd255;
    else if (m >= 8'd144) return 8'd0;
    else return v[7:0];
  endfunction

  function automatic logic is_mid(logic [7:0] a);
    return (a > 8'd10) && (a < 8'd245);
  endfunction

endpackage

@@ hw/rtl/mab_ram.sv @@
module mab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/msdf_atlas_alpha_bake_unit.sv @@
// msdf atlas alpha bake unit
// input stream: tuser carries the opcode (load, read, restart), tdata the
// pixel to load. a load writes the pixel store and updates the coverage
// statistics in the cycle of its transfer, so loads go one per cycle while
// no read blocks the input. a read addresses the pixel store, waits for
// the registered memory data and then converts the pixel into the output
// register: the input is blocked in the cycle after the read transfer,
// and the result is valid on the output stream in the cycle after that.
// a read beyond the loaded pixels, a load into a full store, a restart and
// an unused opcode give no result. tlast marks the final loaded pixel.
// config: cfg_valid_i/cfg_ready_o write sdf_mode, always ready; write it
// only while the block is idle.
// reset clears counts, read index, minima/maxima and sdf_mode; the pixel
// store is not cleared and needs no clearing pass.
// when the receiver stalls the result holds in the output register; loads
// and restarts are still taken, a further read waits until the result is
// transferred.
module msdf_atlas_alpha_bake_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // in_red, in_green, in_blue, in_alpha
  input  logic [1:0]  s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_red, out_green, out_blue, out_alpha
  output logic        m_axis_tlast_o,   // last_pixel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // sdf_mode
);

  mab_pkg::state_e state_q, state_d;

  logic [mab_pkg::CntW-1:0] loaded_count_q, read_index_q;
  logic [mab_pkg::CntW-1:0] mid_pos_q, mid_neg_q;
  logic [7:0]               amin_q [3];
  logic [7:0]               amax_q [3];
  logic                     sdf_mode_q;
  logic                     rd_hit_q, rd_last_q;
  logic                     out_valid_q;
  logic [31:0]              out_data_q;
  logic                     out_last_q;

  logic                     in_xfer, do_load, do_read, do_restart, rd_hit;
  logic [7:0]               in_r, in_g, in_b, in_a, in_m, in_ap, in_an;
  logic [mab_pkg::PixelW-1:0] rdata;
  logic [7:0]               px_r, px_g, px_b, px_a, px_m, px_mx;
  logic [7:0]               cv_r, cv_g, cv_b, cv_a;
  mab_pkg::set_e            sel_set;

  assign cfg_ready_o = 1'b1;

  assign s_axis_tready_o = (state_q == mab_pkg::ST_IDLE) &&
                           (!out_valid_q || m_axis_tready_i ||
                            (s_axis_tuser_i != mab_pkg::OP_READ));

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign do_load    = in_xfer && (s_axis_tuser_i == mab_pkg::OP_LOAD) &&
                      (loaded_count_q != mab_pkg::CntW'(mab_pkg::MaxPixels));
  assign do_read    = in_xfer && (s_axis_tuser_i == mab_pkg::OP_READ);
  assign do_restart = in_xfer && (s_axis_tuser_i == mab_pkg::OP_RESTART);
  assign rd_hit     = read_index_q < loaded_count_q;

  assign in_r  = s_axis_tdata_i[7:0];
  assign in_g  = s_axis_tdata_i[15:8];
  assign in_b  = s_axis_tdata_i[23:16];
  assign in_a  = s_axis_tdata_i[31:24];
  assign in_m  = mab_pkg::med3(in_r, in_g, in_b);
  assign in_ap = mab_pkg::cov_pos(in_m);
  assign in_an = mab_pkg::cov_neg(in_m);

  mab_ram #(
    .Width (mab_pkg::PixelW),
    .Depth (mab_pkg::MaxPixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (loaded_count_q[mab_pkg::AddrW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (do_read && rd_hit),
    .raddr_i (read_index_q[mab_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  // pixel conversion on the registered memory data
  always_comb begin
    px_r = rdata[7:0];
    px_g = rdata[15:8];
    px_b = rdata[23:16];
    px_a = rdata[31:24];
    px_m = mab_pkg::med3(px_r, px_g, px_b);
    cv_r = px_r;
    cv_g = px_g;
    cv_b = px_b;
    cv_a = px_a;
    sel_set = mab_pkg::SET_ORIG;
    if (sdf_mode_q) begin
      cv_r = 8'd255;
      cv_g = 8'd255;
      cv_b = 8'd255;
      if (mid_neg_q > mid_pos_q) begin
        sel_set = mab_pkg::SET_NEG;
        cv_a    = mab_pkg::cov_neg(px_m);
      end else begin
        sel_set = mab_pkg::SET_POS;
        cv_a    = mab_pkg::cov_pos(px_m);
      end
    end
    px_mx = (cv_r > cv_g) ? cv_r : cv_g;
    if (cv_b > px_mx) px_mx = cv_b;
    // flat alpha set: alpha falls back to the brightest output channel, colour to white
    if (amin_q[sel_set] == amax_q[sel_set]) begin
      cv_a = px_mx;
      cv_r = 8'd255;
      cv_g = 8'd255;
      cv_b = 8'd255;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mab_pkg::ST_IDLE: begin
        if (do_read) state_d = mab_pkg::ST_READ;
      end
      mab_pkg::ST_READ: begin
        state_d = mab_pkg::ST_IDLE;
      end
      default: state_d = mab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mab_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdf_mode_q     <= 1'b0;
      loaded_count_q <= '0;
      read_index_q   <= '0;
      mid_pos_q      <= '0;
      mid_neg_q      <= '0;
      rd_hit_q       <= 1'b0;
      rd_last_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        amin_q[k] <= 8'd255;
        amax_q[k] <= 8'd0;
      end
    end else begin
      if (cfg_valid_i) sdf_mode_q <= cfg_data_i;
      if (do_restart) begin
        loaded_count_q <= '0;
        read_index_q   <= '0;
        mid_pos_q      <= '0;
        mid_neg_q      <= '0;
        for (int k = 0; k < 3; k++) begin
          amin_q[k] <= 8'd255;
          amax_q[k] <= 8'd0;
        end
      end
      if (do_load) begin
        loaded_count_q <= loaded_count_q + mab_pkg::CntW'(1);
        if (mab_pkg::is_mid(in_ap)) mid_pos_q <= mid_pos_q + mab_pkg::CntW'(1);
        if (mab_pkg::is_mid(in_an)) mid_neg_q <= mid_neg_q + mab_pkg::CntW'(1);
        if (in_a < amin_q[mab_pkg::SET_ORIG]) amin_q[mab_pkg::SET_ORIG] <= in_a;
        if (in_a > amax_q[mab_pkg::SET_ORIG]) amax_q[mab_pkg::SET_ORIG] <= in_a;
        if (in_ap < amin_q[mab_pkg::SET_POS]) amin_q[mab_pkg::SET_POS] <= in_ap;
        if (in_ap > amax_q[mab_pkg::SET_POS]) amax_q[mab_pkg::SET_POS] <= in_ap;
        if (in_an < amin_q[mab_pkg::SET_NEG]) amin_q[mab_pkg::SET_NEG] <= in_an;
        if (in_an > amax_q[mab_pkg::SET_NEG]) amax_q[mab_pkg::SET_NEG] <= in_an;
      end
      if (do_read) begin
        rd_hit_q  <= rd_hit;
        rd_last_q <= (read_index_q + mab_pkg::CntW'(1)) == loaded_count_q;
        if (rd_hit) read_index_q <= read_index_q + mab_pkg::CntW'(1);
      end
      if (m_axis_tready_i) out_valid_q <= 1'b0;
      if ((state_q == mab_pkg::ST_READ) && rd_hit_q) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == mab_pkg::ST_READ) && rd_hit_q) begin
      out_data_q <= {cv_a, cv_b, cv_g, cv_r};
      out_last_q <= rd_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ hw/rtl/mab_checker.sv @@
module mab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic rd_xfer;
  assign rd_xfer = s_axis_tvalid_i && s_axis_tready_o &&
                   (s_axis_tuser_i == mab_pkg::OP_READ);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // the memory read interlock blocks the cycle after a read
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_xfer |=> !s_axis_tready_o)
    else $error("item taken during memory read");

  // a new result only follows a read transfer, through the memory read and the output register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !$past(m_axis_tvalid_o && !m_axis_tready_i) |->
      $past(rd_xfer, 2))
    else $error("result without read");

endmodule

bind msdf_atlas_alpha_bake_unit mab_checker u_mab_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
